[design/utf8_xmpp_char_sanitizer_macros.svh]
// ----------------------------------------------------------------------------
// utf8_xmpp_char_sanitizer_macros.svh
// assertion helpers shared by the sanitizer modules
// ----------------------------------------------------------------------------
`ifndef UTF8_XMPP_CHAR_SANITIZER_MACROS_SVH
`define UTF8_XMPP_CHAR_SANITIZER_MACROS_SVH

// check on every edge outside reset
`define UXS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check on every edge, reset included
`define UXS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/utf8xs_pkg.sv]
// ----------------------------------------------------------------------------
// utf8xs_pkg
// types, decoder tables and filter functions of the utf-8 sanitizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package utf8xs_pkg;

  // decoder states with a fixed meaning
  localparam logic [3:0] STATE_ACCEPT = 4'd0;
  localparam logic [3:0] STATE_REJECT = 4'd1;
  localparam logic [3:0] STATE_MAX    = 4'd8;

  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned MAX_PENDING = 3;

  // transition table, row = state, column = byte class
  localparam logic [3:0] STEP_TABLE [0:8][0:15] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
      4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
      4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
      4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
      4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
      4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  // result set of one input byte, handed from decoder to output buffer
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [2:0]                  cnt;
    logic                        has;
    logic                        fin;
  } res_set_t;

  // byte class of the decoder
  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] c;
    if (b < 8'h80)       c = 4'd0;
    else if (b < 8'h90)  c = 4'd1;
    else if (b < 8'hA0)  c = 4'd9;
    else if (b < 8'hC0)  c = 4'd7;
    else if (b < 8'hC2)  c = 4'd8;
    else if (b < 8'hE0)  c = 4'd2;
    else if (b == 8'hE0) c = 4'd10;
    else if (b == 8'hED) c = 4'd4;
    else if (b < 8'hF0)  c = 4'd3;
    else if (b == 8'hF0) c = 4'd11;
    else if (b < 8'hF4)  c = 4'd6;
    else if (b == 8'hF4) c = 4'd5;
    else                 c = 4'd8;
    return c;
  endfunction

  // xml character filter; the low-half mask test keeps both 0xffee and 0xffef out
  function automatic logic char_ok(input logic [20:0] cp);
    logic ok;
    if (cp == 21'h09 || cp == 21'h0D || cp == 21'h0A)        ok = 1'b1;
    else if (cp >= 21'h7F && cp <= 21'h84)                    ok = 1'b0;
    else if (cp >= 21'h86 && cp <= 21'h9F)                    ok = 1'b0;
    else if (cp >= 21'hFDD0 && cp <= 21'hFDEF)                ok = 1'b0;
    else if ((cp[15:0] & 16'hFFFE) == 16'hFFEE)               ok = 1'b0;
    else if (cp[15:0] == 16'hFFFF)                            ok = 1'b0;
    else if (cp >= 21'h20 && cp <= 21'hD7FF)                  ok = 1'b1;
    else if (cp >= 21'hE000 && cp <= 21'hFFFD)                ok = 1'b1;
    else if (cp >= 21'h10000 && cp <= 21'h10FFFF)             ok = 1'b1;
    else                                                      ok = 1'b0;
    return ok;
  endfunction

endpackage

`default_nettype wire

[design/utf8_xmpp_char_sanitizer.sv]
// An accepted item waits in the input register until the result buffer is free;
// its result set is then loaded there and offered one result item per cycle while
// out_tready is high. The input takes one item per cycle while the buffer is free,
// and as multi-result items hold the buffer, the single output port sets the rate.
// Reset (rst_n low, synchronous): decoder returns to accept, held bytes and all
// queued items are dropped.
// ----------------------------------------------------------------------------
// utf8_xmpp_char_sanitizer
// utf-8 validator with xml character filter on a byte stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_xmpp_char_sanitizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // stream_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast,  // run_last
  output logic [1:0]      out_tuser   // [0] has_byte, [1] stream_end
);

  logic                 in_valid_r, in_valid_nxt;
  logic [7:0]           in_byte_r;
  logic                 in_last_r;
  logic                 buf_free;
  logic                 advance;
  utf8xs_pkg::res_set_t res;

  // input register moves on once the result buffer can take its set
  assign advance      = in_valid_r && buf_free;
  assign in_tready    = !in_valid_r || advance;
  assign in_valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // decoder and filter
  utf8xs_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_i   (in_byte_r),
    .last_i   (in_last_r),
    .commit_i (advance),
    .res_o    (res)
  );

  // result buffer, loaded only when the item yields results
  utf8xs_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (advance && (res.cnt != 3'd0)),
    .res_i      (res),
    .free_o     (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

[design/utf8xs_decode.sv]
// ----------------------------------------------------------------------------
// utf8xs_decode
// utf-8 decoder state, held sequence bytes and per-byte result set
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_xmpp_char_sanitizer_macros.svh"

module utf8xs_decode (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [7:0]          byte_i,
  input  wire logic                last_i,
  input  wire logic                commit_i,
  output utf8xs_pkg::res_set_t     res_o
);

  logic [3:0]  state_r, state_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [7:0]  pend_r [0:2];

  logic [3:0]  cls;
  logic [3:0]  prev;
  logic [3:0]  first_next;
  logic        restart;
  logic [3:0]  eff_prev;
  logic [1:0]  eff_cnt;
  logic [20:0] acc_new;
  logic [3:0]  next_st;
  logic        emit;
  logic        store;
  logic [2:0]  n_bytes;

  // first pass only tells whether the byte breaks an open sequence
  always_comb begin
    cls        = utf8xs_pkg::byte_class(byte_i);
    prev       = (state_r > utf8xs_pkg::STATE_MAX) ? utf8xs_pkg::STATE_REJECT : state_r;
    first_next = utf8xs_pkg::STEP_TABLE[prev][cls];
    restart    = (first_next == utf8xs_pkg::STATE_REJECT) &&
                 (prev != utf8xs_pkg::STATE_ACCEPT);
    eff_prev   = restart ? utf8xs_pkg::STATE_ACCEPT : prev;
    eff_cnt    = restart ? 2'd0 : cnt_r;
  end

  // decode step from the effective state
  always_comb begin
    if (eff_prev != utf8xs_pkg::STATE_ACCEPT) begin
      acc_new = {acc_r[14:0], byte_i[5:0]};
    end else begin
      acc_new = {13'd0, (8'hFF >> cls) & byte_i};
    end
    next_st = utf8xs_pkg::STEP_TABLE[eff_prev][cls];
    emit    = (next_st == utf8xs_pkg::STATE_ACCEPT) && utf8xs_pkg::char_ok(acc_new);
    store   = (next_st != utf8xs_pkg::STATE_ACCEPT) &&
              (next_st != utf8xs_pkg::STATE_REJECT);
    n_bytes = emit ? ({1'b0, eff_cnt} + 3'd1) : 3'd0;
  end

  // result set: held bytes first, then the current byte
  always_comb begin
    for (int i = 0; i < utf8xs_pkg::MAX_RESULTS; i++) begin
      if (i < int'(eff_cnt)) begin
        res_o.bytes[i] = pend_r[i];
      end else begin
        res_o.bytes[i] = byte_i;
      end
    end
    res_o.has = 1'b1;
    res_o.fin = last_i;
    res_o.cnt = n_bytes;
    if (last_i && (n_bytes == 3'd0)) begin
      res_o.bytes[0] = 8'd0;
      res_o.has      = 1'b0;
      res_o.cnt      = 3'd1;
    end
  end

  // next decoder state
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    if (commit_i) begin
      if (last_i) begin
        state_nxt = utf8xs_pkg::STATE_ACCEPT;
        acc_nxt   = 21'd0;
        cnt_nxt   = 2'd0;
      end else if (next_st == utf8xs_pkg::STATE_REJECT) begin
        state_nxt = utf8xs_pkg::STATE_ACCEPT;
        acc_nxt   = 21'd0;
        cnt_nxt   = 2'd0;
      end else if (next_st == utf8xs_pkg::STATE_ACCEPT) begin
        state_nxt = utf8xs_pkg::STATE_ACCEPT;
        acc_nxt   = acc_new;
        cnt_nxt   = 2'd0;
      end else begin
        state_nxt = next_st;
        acc_nxt   = acc_new;
        cnt_nxt   = (eff_cnt < 2'd3) ? (eff_cnt + 2'd1) : eff_cnt;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= utf8xs_pkg::STATE_ACCEPT;
      acc_r   <= 21'd0;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // held bytes of the open sequence
  always_ff @(posedge clk) begin
    if (commit_i && store && (eff_cnt < 2'd3)) begin
      pend_r[eff_cnt] <= byte_i;
    end
  end

  `UXS_ASSERT(a_state_kept, (state_r != utf8xs_pkg::STATE_REJECT) && (state_r <= utf8xs_pkg::STATE_MAX), "decoder kept reject or out-of-range state")
  `UXS_ASSERT(a_last_clears, commit_i && last_i |=> (state_r == utf8xs_pkg::STATE_ACCEPT) && (cnt_r == 2'd0), "end of string left an open sequence")
  `UXS_ASSERT(a_cnt_tracks, (state_r == utf8xs_pkg::STATE_ACCEPT) |-> (cnt_r == 2'd0), "held bytes without an open sequence")

endmodule

`default_nettype wire

[design/utf8xs_outbuf.sv]
// ----------------------------------------------------------------------------
// utf8xs_outbuf
// result buffer handing out a result set one item per cycle when not stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_xmpp_char_sanitizer_macros.svh"

module utf8xs_outbuf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load_i,
  input  wire utf8xs_pkg::res_set_t res_i,
  output logic                     free_o,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [7:0]               out_tdata,  // [7:0] out_byte
  output logic                     out_tlast,  // run_last
  output logic [1:0]               out_tuser   // [0] has_byte, [1] stream_end
);

  logic [7:0] buf_r [0:utf8xs_pkg::MAX_RESULTS-1];
  logic [2:0] rem_r, rem_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       has_r;
  logic       fin_r;
  logic       take;

  // buffer can take a new set when empty or its final item leaves now
  assign take   = out_tvalid && out_tready;
  assign free_o = (rem_r == 3'd0) || (take && (rem_r == 3'd1));

  // read pointer and remaining count
  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (load_i) begin
      rem_nxt = res_i.cnt;
      idx_nxt = 2'd0;
    end else if (take) begin
      rem_nxt = rem_r - 3'd1;
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      idx_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
      idx_r <= idx_nxt;
    end
  end

  // payload of the buffered set
  always_ff @(posedge clk) begin
    if (load_i) begin
      for (int i = 0; i < utf8xs_pkg::MAX_RESULTS; i++) begin
        buf_r[i] <= res_i.bytes[i];
      end
      has_r <= res_i.has;
      fin_r <= res_i.fin;
    end
  end

  // output item
  assign out_tvalid   = (rem_r != 3'd0);
  assign out_tdata    = buf_r[idx_r];
  assign out_tlast    = (rem_r == 3'd1);
  assign out_tuser[0] = has_r;
  assign out_tuser[1] = fin_r && (rem_r == 3'd1);

  `UXS_ASSERT(a_load_free, load_i |-> free_o, "result set loaded over unsent items")
  `UXS_ASSERT(a_rem_range, rem_r <= 3'd4, "remaining count above four")
  `UXS_ASSERT(a_bare_marker, out_tvalid && !out_tuser[0] |-> out_tlast && out_tuser[1], "bare marker not closing the string")

endmodule

`default_nettype wire

[sim/utf8_xmpp_char_sanitizer_tb.sv]
// ----------------------------------------------------------------------------
// utf8_xmpp_char_sanitizer_tb
// self-checking bench: byte streams go in, sanitized output items are checked
// against an in-bench decoder model, with random gaps and back-pressure
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_xmpp_char_sanitizer_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 200;
  localparam int RANDOM_ITEMS   = 56;

  // decoder transitions, row = state, column = byte class
  localparam logic [3:0] NEXT_STATE [0:8][0:15] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
      4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
      4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
      4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
      4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
      4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       run_last;
    logic       str_end;
  } out_item_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] in_byte
  logic       in_tlast;   // stream_last
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tlast;  // run_last
  logic [1:0] out_tuser;  // [0] has_byte, [1] stream_end

  // model state
  logic [3:0]  dec_state;
  logic [20:0] cp_acc;
  logic [7:0]  held [0:2];
  int          held_cnt;

  out_item_t   sanitized_q [$];
  out_item_t   head_item;
  logic [7:0]  stream_q [$];

  int error_count;
  int items_sent;
  int streams_sent;
  int results_seen;
  int stall_cycles;
  int idle_count;
  int hold_request;
  bit sender_idle;
  bit receiver_idle;

  utf8_xmpp_char_sanitizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // byte class of the decoder
  function automatic logic [3:0] classify_byte(input logic [7:0] b);
    logic [3:0] c;
    if (b < 8'h80)       c = 4'd0;
    else if (b < 8'h90)  c = 4'd1;
    else if (b < 8'hA0)  c = 4'd9;
    else if (b < 8'hC0)  c = 4'd7;
    else if (b < 8'hC2)  c = 4'd8;
    else if (b < 8'hE0)  c = 4'd2;
    else if (b == 8'hE0) c = 4'd10;
    else if (b == 8'hED) c = 4'd4;
    else if (b < 8'hF0)  c = 4'd3;
    else if (b == 8'hF0) c = 4'd11;
    else if (b < 8'hF4)  c = 4'd6;
    else if (b == 8'hF4) c = 4'd5;
    else                 c = 4'd8;
    return c;
  endfunction

  // code points allowed in xml character data, with the ffee/ffef mask
  function automatic bit xml_char_allowed(input logic [20:0] cp);
    bit ok;
    if (cp == 21'h09 || cp == 21'h0A || cp == 21'h0D)           ok = 1'b1;
    else if (cp >= 21'h7F && cp <= 21'h84)                       ok = 1'b0;
    else if (cp >= 21'h86 && cp <= 21'h9F)                       ok = 1'b0;
    else if (cp >= 21'hFDD0 && cp <= 21'hFDEF)                   ok = 1'b0;
    else if ((cp[15:0] & 16'hFFFE) == 16'hFFEE)                  ok = 1'b0;
    else if (cp[15:0] == 16'hFFFF)                               ok = 1'b0;
    else if (cp >= 21'h20 && cp <= 21'hD7FF)                     ok = 1'b1;
    else if (cp >= 21'hE000 && cp <= 21'hFFFD)                   ok = 1'b1;
    else if (cp >= 21'h10000 && cp <= 21'h10FFFF)                ok = 1'b1;
    else                                                         ok = 1'b0;
    return ok;
  endfunction

  // decode one accepted byte and queue the output items it causes
  function automatic void predict_sanitized(input logic [7:0] b, input logic last);
    logic [3:0] prev_st;
    logic [3:0] cls;
    logic [3:0] nxt_st;
    out_item_t  res [0:3];
    int         n;
    bit         done;
    n    = 0;
    done = 1'b0;
    for (int pass_no = 0; pass_no < 2 && !done; pass_no++) begin
      prev_st = (dec_state > utf8xs_pkg::STATE_MAX) ? utf8xs_pkg::STATE_REJECT : dec_state;
      cls     = classify_byte(b);
      if (prev_st != utf8xs_pkg::STATE_ACCEPT) cp_acc = {cp_acc[14:0], b[5:0]};
      else cp_acc = {13'd0, b & (8'hFF >> cls)};
      nxt_st = NEXT_STATE[prev_st][cls];
      if (nxt_st == utf8xs_pkg::STATE_ACCEPT) begin
        // sequence complete: release held bytes if the character passes
        if (xml_char_allowed(cp_acc)) begin
          for (int i = 0; i < held_cnt; i++) begin
            res[n] = {held[i], 1'b1, 1'b0, 1'b0};
            n++;
          end
          res[n] = {b, 1'b1, 1'b0, 1'b0};
          n++;
        end
        held_cnt  = 0;
        dec_state = utf8xs_pkg::STATE_ACCEPT;
        done      = 1'b1;
      end else if (nxt_st == utf8xs_pkg::STATE_REJECT) begin
        // drop the open sequence; a byte that broke it is decoded again
        held_cnt  = 0;
        dec_state = utf8xs_pkg::STATE_ACCEPT;
        cp_acc    = '0;
        if (prev_st == utf8xs_pkg::STATE_ACCEPT) done = 1'b1;
      end else begin
        if (held_cnt < utf8xs_pkg::MAX_PENDING) begin
          held[held_cnt] = b;
          held_cnt++;
        end
        dec_state = nxt_st;
        done      = 1'b1;
      end
    end
    // end of string: flush state, mark the final item
    if (last) begin
      dec_state = utf8xs_pkg::STATE_ACCEPT;
      cp_acc    = '0;
      held_cnt  = 0;
      if (n == 0) begin
        res[0] = {8'h00, 1'b0, 1'b0, 1'b0};
        n = 1;
      end
      res[n-1].str_end = 1'b1;
    end
    if (n > 0) res[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) sanitized_q.insert(sanitized_q.size(), res[i]);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input bit enabled);
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) g = 0;
    else if (r < 90)        g = $urandom_range(1, 3);
    else                    g = $urandom_range(8, 30);
    return g;
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // append one byte to the string being built
  function automatic void add_byte(input logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endfunction

  // offer one item and wait for it to be taken
  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap(sender_idle);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    predict_sanitized(b, last);
  endtask

  // send the collected bytes as one string, last flag on the final one
  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++) send_item(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
    streams_sent++;
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // one random sequence: mostly well-formed, some near filter edges,
  // some noise and truncated sequences
  task automatic push_random_seq();
    int         kind;
    logic [7:0] lead;
    int         conts;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      add_byte(8'($urandom_range(0, 127)));
    end else if (kind < 40) begin
      add_byte(8'($urandom_range(8'hC2, 8'hDF)));
      add_byte(cont_byte());
    end else if (kind < 55) begin
      lead = 8'($urandom_range(8'hE0, 8'hEF));
      add_byte(lead);
      if (lead == 8'hE0)      add_byte(8'($urandom_range(8'hA0, 8'hBF)));
      else if (lead == 8'hED) add_byte(8'($urandom_range(8'h80, 8'h9F)));
      else                    add_byte(cont_byte());
      add_byte(cont_byte());
    end else if (kind < 67) begin
      lead = 8'($urandom_range(8'hF0, 8'hF4));
      add_byte(lead);
      if (lead == 8'hF0)      add_byte(8'($urandom_range(8'h90, 8'hBF)));
      else if (lead == 8'hF4) add_byte(8'($urandom_range(8'h80, 8'h8F)));
      else                    add_byte(cont_byte());
      add_byte(cont_byte());
      add_byte(cont_byte());
    end else if (kind < 80) begin
      // code points around the filter boundaries
      case ($urandom_range(0, 3))
        0: begin
          add_byte(8'hEF);
          add_byte(8'hB7);
          add_byte(8'($urandom_range(8'h8E, 8'hB1)));
        end
        1: begin
          add_byte(8'hEF);
          add_byte(8'hBF);
          add_byte(8'($urandom_range(8'hAC, 8'hBF)));
        end
        2: begin
          add_byte(8'($urandom_range(8'hF0, 8'hF3)) | 8'h01);
          add_byte(8'h8F | 8'($urandom_range(0, 3) << 4));
          add_byte(8'hBF);
          add_byte(8'($urandom_range(8'hAC, 8'hBF)));
        end
        default: begin
          add_byte(8'hC2);
          add_byte(8'($urandom_range(8'h80, 8'hA1)));
        end
      endcase
    end else if (kind < 90) begin
      add_byte(8'($urandom_range(0, 255)));
    end else begin
      // truncated sequence, then at times an arbitrary byte
      lead  = 8'($urandom_range(8'hC2, 8'hF4));
      conts = (lead < 8'hE0) ? 0 : $urandom_range(0, (lead < 8'hF0) ? 1 : 2);
      add_byte(lead);
      for (int i = 0; i < conts; i++) add_byte(8'h80 | 8'($urandom_range(0, 31)));
      if ($urandom_range(0, 1)) add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // ascii extremes, filtered controls and invalid lead bytes
  task automatic test_ascii_and_lead_errors();
    stream_q = '{8'h00, 8'h09, 8'h0D, 8'h20, 8'h7F, 8'hFF, 8'hC0, 8'h41};
    send_stream();
  endtask

  // two- and four-byte characters, then a broken sequence that recovers
  task automatic test_multibyte_and_recovery();
    stream_q = '{8'hC2, 8'h85, 8'hF4, 8'h8F, 8'hBF, 8'hBD, 8'hE2, 8'h41};
    send_stream();
  endtask

  // masked u+ffee, stray continuation, unfinished sequence at the end
  task automatic test_filter_and_truncation();
    stream_q = '{8'hEF, 8'hBF, 8'hAE, 8'h80, 8'hE2, 8'h82};
    send_stream();
  endtask

  // string that ends with nothing emitted
  task automatic test_bare_end();
    stream_q = '{8'hFF};
    send_stream();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    sender_idle  = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 10; i++) begin
      add_byte(8'hF0);
      add_byte(8'h9F);
      add_byte(cont_byte());
      add_byte(cont_byte());
    end
    send_stream();
    sender_idle = 1'b1;
  endtask

  // random strings, with a stretch of no idling in the middle
  task automatic test_random_streams();
    int start_items;
    int nseq;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      sender_idle   = !((items_sent - start_items) inside {[20:40]});
      receiver_idle = sender_idle;
      nseq = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
      for (int i = 0; i < nseq; i++) push_random_seq();
      send_stream();
    end
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // receiver: random stalls plus an on-request long hold-off
  initial begin : receiver
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (receiver_idle && $urandom_range(0, 99) < 25) begin
        out_tready <= 1'b0;
        stall_left = pick_gap(1'b1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready) stall_cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (sanitized_q.size() == 0) begin
        $error("unexpected output item: out_byte %02h has_byte %0b", out_tdata, out_tuser[0]);
        error_count++;
      end else begin
        head_item = sanitized_q.pop_front();
        if (out_tdata !== head_item.data) begin
          $error("out_byte: expected %02h, actual %02h", head_item.data, out_tdata);
          error_count++;
        end
        if (out_tuser[0] !== head_item.has) begin
          $error("has_byte: expected %0b, actual %0b", head_item.has, out_tuser[0]);
          error_count++;
        end
        if (out_tlast !== head_item.run_last) begin
          $error("run_last: expected %0b, actual %0b", head_item.run_last, out_tlast);
          error_count++;
        end
        if (out_tuser[1] !== head_item.str_end) begin
          $error("stream_end: expected %0b, actual %0b", head_item.str_end, out_tuser[1]);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("utf8_xmpp_char_sanitizer verification failed");
      $finish;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = 8'h00;
    in_tlast      = 1'b0;
    out_tready    = 1'b0;
    dec_state     = utf8xs_pkg::STATE_ACCEPT;
    cp_acc        = '0;
    held_cnt      = 0;
    error_count   = 0;
    items_sent    = 0;
    streams_sent  = 0;
    results_seen  = 0;
    stall_cycles  = 0;
    idle_count    = 0;
    hold_request  = 0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_ascii_and_lead_errors();
    test_multibyte_and_recovery();
    test_filter_and_truncation();
    test_bare_end();
    test_backpressure();
    test_random_streams();

    // drain outstanding items, then watch for strays
    while (sanitized_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d input items in %0d strings, %0d output items checked",
             items_sent, streams_sent, results_seen);
    $display("input side held off %0d cycles by output back-pressure", stall_cycles);
    if (error_count == 0) begin
      $display("utf8_xmpp_char_sanitizer verification clean");
    end else begin
      $display("utf8_xmpp_char_sanitizer verification failed");
    end
    $finish;
  end

endmodule
